// ===== src/vcfp_pkg.sv =====
// ----------------------------------------------------------------------------
// vcfp_pkg
// Shared types and constants for the velocity command frame parser.
// ----------------------------------------------------------------------------
package vcfp_pkg;

  localparam int unsigned FrameLen     = 15;
  localparam int unsigned PosWidth     = 4;
  localparam int unsigned WordWidth    = 32;
  localparam int unsigned OutDataWidth = 3 * WordWidth;

  localparam logic [PosWidth-1:0] FrameLenPos     = PosWidth'(FrameLen);
  localparam logic [PosWidth-1:0] PayloadFirstPos = PosWidth'(2);
  localparam logic [PosWidth-1:0] PayloadLastPos  = PosWidth'(13);
  localparam logic [PosWidth-1:0] CheckPos        = PosWidth'(14);
  localparam logic [7:0]          HeaderByte      = 8'hFF;

  typedef enum logic {
    KindByte = 1'b0,
    KindIdle = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    WordX    = 2'd0,
    WordY    = 2'd1,
    WordSpin = 2'd2
  } word_sel_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic                 frame_ok;
    logic [WordWidth-1:0] spin_bits;
    logic [WordWidth-1:0] vel_y_bits;
    logic [WordWidth-1:0] vel_x_bits;
  } result_t;

endpackage

// ===== src/velocity_command_frame_parser_top.sv =====
// ----------------------------------------------------------------------------
// velocity_command_frame_parser_top
// Checks fifteen-byte velocity command frames and emits the three words.
// ----------------------------------------------------------------------------
// Takes one item per clock. Byte items update the frame state and give no
// result; an idle item closes the burst and its result is registered: the
// accepting edge loads the input register, and the result register is loaded
// when the idle item leaves it. Only an idle item meeting a full result
// register that is not being drained holds the input side; byte items always
// flow.
module velocity_command_frame_parser_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [7:0]                     s_axis_tdata_i,  // [7:0] data_byte
  input  logic                           s_axis_tuser_i,  // [0] kind
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [31:0] vel_x_bits, [63:32] vel_y_bits, [95:64] spin_bits
  output logic [vcfp_pkg::OutDataWidth-1:0] m_axis_tdata_o,
  output logic                           m_axis_tuser_o   // [0] frame_ok
);
  import vcfp_pkg::*;

  item_t   in_item;
  item_t   s1_item;
  logic    s1_valid;
  logic    s1_pop;
  logic    push;
  logic    out_ready;
  logic    out_load;
  result_t core_result;
  result_t out_result;

  assign in_item.kind      = kind_e'(s_axis_tuser_i);
  assign in_item.data_byte = s_axis_tdata_i;

  assign s1_pop          = s1_valid && ((s1_item.kind == KindByte) || out_ready);
  assign s_axis_tready_o = !s1_valid || s1_pop;
  assign push            = s_axis_tvalid_i && s_axis_tready_o;
  assign out_load        = s1_pop && (s1_item.kind == KindIdle);

  vcfp_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (in_item),
    .pop_i   (s1_pop),
    .valid_o (s1_valid),
    .item_o  (s1_item)
  );

  vcfp_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (s1_pop),
    .item_i   (s1_item),
    .result_o (core_result)
  );

  vcfp_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (out_load),
    .result_i (core_result),
    .take_i   (m_axis_tvalid_o && m_axis_tready_i),
    .ready_o  (out_ready),
    .valid_o  (m_axis_tvalid_o),
    .result_o (out_result)
  );

  assign m_axis_tdata_o = {out_result.spin_bits, out_result.vel_y_bits,
                           out_result.vel_x_bits};
  assign m_axis_tuser_o = out_result.frame_ok;

endmodule

// ===== src/vcfp_in_stage.sv =====
// ----------------------------------------------------------------------------
// vcfp_in_stage
// Input register: holds one accepted item until the frame logic takes it.
// ----------------------------------------------------------------------------
module vcfp_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  vcfp_pkg::item_t item_i,
  input  logic           pop_i,
  output logic           valid_o,
  output vcfp_pkg::item_t item_o
);
  import vcfp_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;

  always_comb begin
    valid_d = valid_q;
    if (pop_i) begin
      valid_d = 1'b0;
    end
    if (push_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== src/vcfp_core.sv =====
// ----------------------------------------------------------------------------
// vcfp_core
// Frame state: position, header flag, running XOR, check byte and the three
// assembled words. Judges the frame when an idle item is taken.
// ----------------------------------------------------------------------------
module vcfp_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  vcfp_pkg::item_t   item_i,
  output vcfp_pkg::result_t result_o
);
  import vcfp_pkg::*;

  logic [PosWidth-1:0]  pos_q, pos_d;
  logic [7:0]           xor_q, xor_d;
  logic                 hdr_q, hdr_d;
  logic [7:0]           chk_q, chk_d;
  logic [WordWidth-1:0] wx_q, wx_d;
  logic [WordWidth-1:0] wy_q, wy_d;
  logic [WordWidth-1:0] ws_q, ws_d;

  logic [PosWidth-1:0]  off;
  logic [WordWidth-1:0] lane_word;
  logic [WordWidth-1:0] lane_mask;
  logic                 ok;

  assign off       = pos_q - PayloadFirstPos;
  assign lane_word = WordWidth'(item_i.data_byte) << {off[1:0], 3'b000};
  assign lane_mask = WordWidth'(8'hFF) << {off[1:0], 3'b000};

  assign ok = (pos_q == FrameLenPos) && hdr_q && (chk_q == xor_q);

  always_comb begin
    result_o.frame_ok   = ok;
    result_o.vel_x_bits = ok ? wx_q : '0;
    result_o.vel_y_bits = ok ? wy_q : '0;
    result_o.spin_bits  = ok ? ws_q : '0;
  end

  always_comb begin
    pos_d = pos_q;
    xor_d = xor_q;
    hdr_d = hdr_q;
    chk_d = chk_q;
    wx_d  = wx_q;
    wy_d  = wy_q;
    ws_d  = ws_q;
    if (fire_i) begin
      if (item_i.kind == KindIdle) begin
        pos_d = '0;
        xor_d = '0;
        hdr_d = 1'b1;
        chk_d = '0;
        wx_d  = '0;
        wy_d  = '0;
        ws_d  = '0;
      end else if (pos_q < FrameLenPos) begin
        pos_d = pos_q + PosWidth'(1);
        if (pos_q < PayloadFirstPos) begin
          if (item_i.data_byte != HeaderByte) begin
            hdr_d = 1'b0;
          end
        end else if (pos_q <= PayloadLastPos) begin
          xor_d = xor_q ^ item_i.data_byte;
          unique case (word_sel_e'(off[3:2]))
            WordX:    wx_d = (wx_q & ~lane_mask) | lane_word;
            WordY:    wy_d = (wy_q & ~lane_mask) | lane_word;
            WordSpin: ws_d = (ws_q & ~lane_mask) | lane_word;
            default:  ;
          endcase
        end else if (pos_q == CheckPos) begin
          chk_d = item_i.data_byte;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      xor_q <= '0;
      hdr_q <= 1'b1;
      chk_q <= '0;
      wx_q  <= '0;
      wy_q  <= '0;
      ws_q  <= '0;
    end else begin
      pos_q <= pos_d;
      xor_q <= xor_d;
      hdr_q <= hdr_d;
      chk_q <= chk_d;
      wx_q  <= wx_d;
      wy_q  <= wy_d;
      ws_q  <= ws_d;
    end
  end

endmodule

// ===== src/vcfp_out_stage.sv =====
// ----------------------------------------------------------------------------
// vcfp_out_stage
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module vcfp_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  vcfp_pkg::result_t result_i,
  input  logic              take_i,
  output logic              ready_o,
  output logic              valid_o,
  output vcfp_pkg::result_t result_o
);
  import vcfp_pkg::*;

  logic    valid_q, valid_d;
  result_t result_q;

  assign ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (take_i) begin
      valid_d = 1'b0;
    end
    if (load_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

// ===== src/vcfp_checker.sv =====
// ----------------------------------------------------------------------------
// vcfp_checker
// Port-level checks for the velocity command frame parser.
// ----------------------------------------------------------------------------
module vcfp_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid_i,
  input logic                              s_axis_tready_o,
  input logic [7:0]                        s_axis_tdata_i,
  input logic                              s_axis_tuser_i,
  input logic                              m_axis_tvalid_o,
  input logic                              m_axis_tready_i,
  input logic [vcfp_pkg::OutDataWidth-1:0] m_axis_tdata_o,
  input logic                              m_axis_tuser_o
);
  import vcfp_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // failed frame carries zero words
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o == '0)
    else $error("nonzero words on bad frame");

  // empty result register never blocks input
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input blocked with empty result register");

endmodule

bind velocity_command_frame_parser_top vcfp_checker u_vcfp_checker (.*);
